// ----- rtl/core/ccr_pkg.sv -----
// Shared types, codes and constants of the character canvas rasterizer.
package ccr_pkg;

	localparam int COORD_BITS = 12;
	localparam int RADIUS_BITS = 11;
	localparam int CHAR_BITS = 8;
	localparam int WIDTH_REG_BITS = 7;
	localparam int HEIGHT_REG_BITS = 6;
	localparam int MAX_WIDTH_DEF = 64;
	localparam int MAX_HEIGHT_DEF = 32;

	localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 7'd64;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 6'd32;
	localparam logic [CHAR_BITS-1:0] BLANK = 8'h20;

	// Midpoint circle decision constants.
	localparam int CIRC_D0 = 3;
	localparam int CIRC_INC_A = 6;
	localparam int CIRC_INC_B = 10;

	// Operation codes.
	localparam logic [2:0] OP_POINT = 3'd0;
	localparam logic [2:0] OP_LINE = 3'd1;
	localparam logic [2:0] OP_RECT = 3'd2;
	localparam logic [2:0] OP_FILL = 3'd3;
	localparam logic [2:0] OP_CIRCLE = 3'd4;
	localparam logic [2:0] OP_DISC = 3'd5;
	localparam logic [2:0] OP_CLEAR = 3'd6;
	localparam logic [2:0] OP_READ = 3'd7;

	// Register indexes.
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [2:0] op;
		logic signed [COORD_BITS-1:0] x_a;
		logic signed [COORD_BITS-1:0] y_a;
		logic signed [COORD_BITS-1:0] x_b;
		logic signed [COORD_BITS-1:0] y_b;
		logic [RADIUS_BITS-1:0] radius;
		logic [CHAR_BITS-1:0] draw_char;
	} req_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] read_char;
		logic read_inside;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic clr;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic last;
		logic is_clr;
		logic clr_last;
	} stat_t;

endpackage

// ----- rtl/core/ccr_dp.sv -----
// Datapath of the rasterizer: pixel walkers, frame store and result register.
module ccr_dp #(
	parameter int MAX_WIDTH = ccr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ccr_pkg::MAX_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input ccr_pkg::ctl_t ctl,
	output ccr_pkg::stat_t stat,
	input ccr_pkg::req_t req,
	input logic [ccr_pkg::WIDTH_REG_BITS-1:0] act_w,
	input logic [ccr_pkg::HEIGHT_REG_BITS-1:0] act_h,
	output ccr_pkg::rsp_t rsp
);

	localparam int CB = ccr_pkg::COORD_BITS;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int P = CB + 2;
	localparam int E = CB + 4;
	localparam int D = CB + 5;
	localparam int RB = 2 * ccr_pkg::RADIUS_BITS;
	localparam int SQ = 2 * P;
	localparam logic [1:0] SEG_ROWS = 2'd0;
	localparam logic [1:0] SEG_COLS = 2'd1;
	localparam logic [1:0] SEG_NONE = 2'd2;
	localparam logic signed [P-1:0] ONE = P'(1);

	logic [2:0] op_q;
	logic [ccr_pkg::CHAR_BITS-1:0] ch_q;
	logic signed [P-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
	logic sx_q, sy_q, empty_q;
	logic signed [E-1:0] err_q;
	logic signed [D-1:0] dd_q;
	logic [RB-1:0] rr_q;
	logic [SQ-1:0] sqi_q, sqj_q;
	logic [1:0] seg_q;
	logic [2:0] ph_q;
	logic [AW-1:0] clr_cnt_q;
	logic [ccr_pkg::CHAR_BITS-1:0] rdata_q;
	ccr_pkg::rsp_t res_q;
	logic [ccr_pkg::CHAR_BITS-1:0] mem [DEPTH];

	logic signed [P-1:0] ew, eh;
	logic signed [P-1:0] xa_e, ya_e, xb_e, yb_e, rad_e;
	logic signed [P-1:0] fl, ft, fr, fb;
	logic signed [P-1:0] px, py, lo_x;
	logic pen, last, ins, advance;
	logic signed [P-1:0] nxt_cx, nxt_cy;
	logic signed [E-1:0] nxt_err, e2, dx_e, dy_e;
	logic signed [D-1:0] nxt_dd;
	logic [1:0] nxt_seg;
	logic [2:0] nxt_ph;
	logic signed [P-1:0] di, dj;
	logic signed [SQ-1:0] pi, pj;
	logic [SQ:0] sq_sum;
	logic [AW-1:0] pa, waddr, px_a, py_a;
	logic [ccr_pkg::CHAR_BITS-1:0] wdata;
	logic we;
	logic signed [P-1:0] ld_ax, ld_ay, ld_bx, ld_by, ld_cx, ld_cy;
	logic ld_empty;
	logic [1:0] ld_seg;

	assign ew = (int'(act_w) > MAX_WIDTH) ? P'(MAX_WIDTH) : P'(act_w);
	assign eh = (int'(act_h) > MAX_HEIGHT) ? P'(MAX_HEIGHT) : P'(act_h);

	assign xa_e = {{(P-CB){req.x_a[CB-1]}}, req.x_a};
	assign ya_e = {{(P-CB){req.y_a[CB-1]}}, req.y_a};
	assign xb_e = {{(P-CB){req.x_b[CB-1]}}, req.x_b};
	assign yb_e = {{(P-CB){req.y_b[CB-1]}}, req.y_b};
	assign rad_e = P'(req.radius);

	// Fill bounds clamped to the active canvas.
	assign fl = (xa_e < 0) ? '0 : xa_e;
	assign ft = (ya_e < 0) ? '0 : ya_e;
	assign fr = (xb_e > ew - ONE) ? ew - ONE : xb_e;
	assign fb = (yb_e > eh - ONE) ? eh - ONE : yb_e;

	assign dx_e = {{(E-P){dx_q[P-1]}}, dx_q};
	assign dy_e = {{(E-P){dy_q[P-1]}}, dy_q};
	assign e2 = err_q <<< 1;
	assign lo_x = (op_q == ccr_pkg::OP_DISC) ? '0 : ax_q;
	assign di = cx_q - ax_q;
	assign dj = cy_q - ay_q;
	assign pi = SQ'(di) * SQ'(di);
	assign pj = SQ'(dj) * SQ'(dj);
	assign sq_sum = {1'b0, sqi_q} + {1'b0, sqj_q};

	always_comb begin
		px = ax_q;
		py = ay_q;
		pen = 1'b0;
		last = 1'b0;
		advance = 1'b0;
		nxt_cx = cx_q;
		nxt_cy = cy_q;
		nxt_err = err_q;
		nxt_dd = dd_q;
		nxt_seg = seg_q;
		nxt_ph = ph_q;
		unique case (op_q)
			ccr_pkg::OP_POINT: begin
				pen = 1'b1;
				last = 1'b1;
			end
			ccr_pkg::OP_LINE: begin
				px = cx_q;
				py = cy_q;
				pen = 1'b1;
				if (cx_q == bx_q && cy_q == by_q) begin
					last = 1'b1;
				end else begin
					if (e2 >= dy_e) begin
						nxt_err = nxt_err + dy_e;
						nxt_cx = sx_q ? cx_q + ONE : cx_q - ONE;
					end
					if (e2 <= dx_e) begin
						nxt_err = nxt_err + dx_e;
						nxt_cy = sy_q ? cy_q + ONE : cy_q - ONE;
					end
				end
			end
			ccr_pkg::OP_RECT: begin
				if (seg_q == SEG_ROWS) begin
					px = cx_q;
					py = ph_q[0] ? by_q : ay_q;
					pen = 1'b1;
					nxt_ph = {2'b00, ~ph_q[0]};
					if (ph_q[0] && cx_q == bx_q) begin
						if (ay_q <= by_q) begin
							nxt_seg = SEG_COLS;
							nxt_cx = ay_q;
						end else begin
							last = 1'b1;
						end
					end else if (ph_q[0]) begin
						nxt_cx = cx_q + ONE;
					end
				end else if (seg_q == SEG_COLS) begin
					px = ph_q[0] ? bx_q : ax_q;
					py = cx_q;
					pen = 1'b1;
					nxt_ph = {2'b00, ~ph_q[0]};
					if (ph_q[0] && cx_q == by_q) begin
						last = 1'b1;
					end else if (ph_q[0]) begin
						nxt_cx = cx_q + ONE;
					end
				end else begin
					last = 1'b1;
				end
			end
			ccr_pkg::OP_FILL, ccr_pkg::OP_DISC: begin
				px = cx_q;
				py = cy_q;
				if (op_q == ccr_pkg::OP_FILL) begin
					advance = 1'b1;
					pen = 1'b1;
				end else begin
					advance = ph_q[0];
					pen = ph_q[0] && (sq_sum <= (SQ+1)'(rr_q));
					nxt_ph = {2'b00, ~ph_q[0]};
				end
				if (empty_q) begin
					pen = 1'b0;
					last = 1'b1;
				end else if (advance) begin
					if (cx_q == bx_q) begin
						if (cy_q == by_q) begin
							last = 1'b1;
						end else begin
							nxt_cy = cy_q + ONE;
							nxt_cx = lo_x;
						end
					end else begin
						nxt_cx = cx_q + ONE;
					end
				end
			end
			ccr_pkg::OP_CIRCLE: begin
				pen = 1'b1;
				nxt_ph = ph_q + 3'd1;
				// Eight octant reflections of the current (x, y) offset.
				unique case (ph_q)
					3'd0: begin px = ax_q + cx_q; py = ay_q + cy_q; end
					3'd1: begin px = ax_q - cx_q; py = ay_q + cy_q; end
					3'd2: begin px = ax_q + cx_q; py = ay_q - cy_q; end
					3'd3: begin px = ax_q - cx_q; py = ay_q - cy_q; end
					3'd4: begin px = ax_q + cy_q; py = ay_q + cx_q; end
					3'd5: begin px = ax_q - cy_q; py = ay_q + cx_q; end
					3'd6: begin px = ax_q + cy_q; py = ay_q - cx_q; end
					default: begin px = ax_q - cy_q; py = ay_q - cx_q; end
				endcase
				if (ph_q == 3'd7) begin
					if (dd_q < 0) begin
						nxt_dd = dd_q + (D'(cx_q) <<< 2) + D'(ccr_pkg::CIRC_INC_A);
					end else begin
						nxt_dd = dd_q + (D'(cx_q - cy_q) <<< 2)
							+ D'(ccr_pkg::CIRC_INC_B);
						nxt_cy = cy_q - ONE;
					end
					nxt_cx = cx_q + ONE;
					last = (nxt_cy < nxt_cx);
				end
			end
			default: begin
				// Read and clear walk no pixels.
				last = 1'b1;
			end
		endcase
	end

	// Walker start values for a newly accepted request.
	always_comb begin
		ld_ax = xa_e;
		ld_ay = ya_e;
		ld_bx = xb_e;
		ld_by = yb_e;
		ld_cx = xa_e;
		ld_cy = ya_e;
		ld_empty = 1'b0;
		ld_seg = SEG_NONE;
		unique case (req.op)
			ccr_pkg::OP_RECT: begin
				if (xa_e <= xb_e) begin
					ld_seg = SEG_ROWS;
				end else if (ya_e <= yb_e) begin
					ld_seg = SEG_COLS;
					ld_cx = ya_e;
				end
			end
			ccr_pkg::OP_FILL: begin
				ld_ax = fl;
				ld_ay = ft;
				ld_bx = fr;
				ld_by = fb;
				ld_cx = fl;
				ld_cy = ft;
				ld_empty = (fl > fr) || (ft > fb);
			end
			ccr_pkg::OP_CIRCLE: begin
				ld_cx = '0;
				ld_cy = rad_e;
			end
			ccr_pkg::OP_DISC: begin
				ld_bx = ew - ONE;
				ld_by = eh - ONE;
				ld_cx = '0;
				ld_cy = '0;
				ld_empty = (ew == 0) || (eh == 0);
			end
			default: begin
			end
		endcase
	end

	assign ins = (px >= 0) && (px < ew) && (py >= 0) && (py < eh);
	assign px_a = AW'(px);
	assign py_a = AW'(py);
	assign pa = AW'(py_a * AW'(MAX_WIDTH)) + px_a;
	assign we = ctl.clr || (ctl.step && pen && ins);
	assign waddr = ctl.clr ? clr_cnt_q : pa;
	assign wdata = ctl.clr ? ccr_pkg::BLANK : ch_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[pa];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clr) begin
			clr_cnt_q <= stat.clr_last ? '0 : clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q <= req.op;
			ch_q <= req.draw_char;
			ph_q <= '0;
			ax_q <= ld_ax;
			ay_q <= ld_ay;
			bx_q <= ld_bx;
			by_q <= ld_by;
			cx_q <= ld_cx;
			cy_q <= ld_cy;
			dx_q <= (xb_e > xa_e) ? xb_e - xa_e : xa_e - xb_e;
			dy_q <= (yb_e > ya_e) ? ya_e - yb_e : yb_e - ya_e;
			sx_q <= (xa_e < xb_e);
			sy_q <= (ya_e < yb_e);
			err_q <= E'((xb_e > xa_e) ? xb_e - xa_e : xa_e - xb_e)
				+ E'((yb_e > ya_e) ? ya_e - yb_e : yb_e - ya_e);
			dd_q <= D'(ccr_pkg::CIRC_D0) - (D'(rad_e) <<< 1);
			rr_q <= RB'(req.radius) * RB'(req.radius);
			empty_q <= ld_empty;
			seg_q <= ld_seg;
		end else if (ctl.step) begin
			if (op_q == ccr_pkg::OP_DISC && !ph_q[0]) begin
				sqi_q <= unsigned'(pi);
				sqj_q <= unsigned'(pj);
			end
			cx_q <= nxt_cx;
			cy_q <= nxt_cy;
			err_q <= nxt_err;
			dd_q <= nxt_dd;
			seg_q <= nxt_seg;
			ph_q <= nxt_ph;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			res_q.read_char <= (op_q == ccr_pkg::OP_READ && ins) ? rdata_q : '0;
			res_q.read_inside <= (op_q == ccr_pkg::OP_READ && ins);
		end
	end

	assign stat.last = last;
	assign stat.is_clr = (op_q == ccr_pkg::OP_CLEAR);
	assign stat.clr_last = (clr_cnt_q == AW'(DEPTH - 1));
	assign rsp = res_q;

endmodule

// ----- rtl/core/ccr_ctrl.sv -----
// Controller of the rasterizer: sweep, run, finish and result handshake.
module ccr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	output ccr_pkg::ctl_t ctl,
	input ccr_pkg::stat_t stat
);

	localparam logic [1:0] S_SWEEP = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_RUN = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	logic [1:0] state_q, state_nxt;
	logic ov_q;

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = ov_q;
	assign ctl.load = cmd_valid && (state_q == S_IDLE);
	assign ctl.clr = (state_q == S_SWEEP) || (state_q == S_RUN && stat.is_clr);
	assign ctl.step = (state_q == S_RUN) && !stat.is_clr;
	assign ctl.finish = (state_q == S_FIN) && (!ov_q || rsp_ready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_SWEEP: if (stat.clr_last) state_nxt = S_IDLE;
			S_IDLE: if (ctl.load) state_nxt = S_RUN;
			S_RUN: begin
				if (stat.is_clr ? stat.clr_last : stat.last) state_nxt = S_FIN;
			end
			default: if (ctl.finish) state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.finish) begin
				ov_q <= 1'b1;
			end else if (rsp_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> state_q == S_RUN)
		else $error("accepted request did not start work");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> (!ov_q || rsp_ready))
		else $error("result overwritten while pending");
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> rsp_valid)
		else $error("finished request produced no result");
	a_sweep_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWEEP |-> !cmd_ready && !ctl.step)
		else $error("request taken during store sweep");

endmodule

// ----- rtl/core/char_canvas_rasterizer_unit.sv -----
// Top level of the character canvas rasterizer with its configuration registers.
//
// Usage: a request on cmd_valid/cmd_ready carries one drawing command (point,
// line, rectangle outline, rectangle fill, circle, disc, clear or read). It is
// taken only while the engine is idle, and exactly one result appears on
// rsp_valid/rsp_ready for each request; a read returns the cell and whether the
// coordinate lies inside the active canvas.
// A request passes through the idle state in which it is accepted, its walk,
// and the finish state, which loads the result but waits while an earlier
// result is pending. The walk is set by the single write port of the frame
// store, at most one cell per cycle: a point writes its cell, a read or an
// empty shape none, a line each pixel, a rectangle outline the top and bottom
// cell of each column and then the left and right cell of each row, a fill
// each clipped cell, a circle each octant reflection of every midpoint step, a
// disc each covered active cell, and a clear all MAX_WIDTH*MAX_HEIGHT cells.
// After reset the store is swept to spaces, all MAX_WIDTH*MAX_HEIGHT cells
// (2048 by default), while cmd_ready stays low; APB writes to canvas_width and
// canvas_height are taken at all times but belong only to idle periods.
// A finished result waits in an output register while the receiver stalls, and
// the next request is already accepted; its own result is held back until the
// previous one has been taken.
module char_canvas_rasterizer_unit #(
	parameter int MAX_WIDTH = ccr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ccr_pkg::MAX_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic cmd_valid,
	output logic cmd_ready,
	input ccr_pkg::req_t cmd_data,
	output logic rsp_valid,
	input logic rsp_ready,
	output ccr_pkg::rsp_t rsp_data
);

	logic [ccr_pkg::WIDTH_REG_BITS-1:0] width_q;
	logic [ccr_pkg::HEIGHT_REG_BITS-1:0] height_q;
	ccr_pkg::ctl_t ctl;
	ccr_pkg::stat_t stat;

	// Registers sit at byte addresses 0 and 4; bit 2 selects the register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ccr_pkg::WIDTH_RESET;
			height_q <= ccr_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == ccr_pkg::REG_WIDTH) begin
				width_q <= pwdata[ccr_pkg::WIDTH_REG_BITS-1:0];
			end else begin
				height_q <= pwdata[ccr_pkg::HEIGHT_REG_BITS-1:0];
			end
		end
	end

	// Read data is the selected register, zero extended.
	assign prdata = (paddr[2] == ccr_pkg::REG_WIDTH) ? 32'(width_q) : 32'(height_q);

	ccr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.ctl(ctl),
		.stat(stat)
	);

	ccr_dp #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.stat(stat),
		.req(cmd_data),
		.act_w(width_q),
		.act_h(height_q),
		.rsp(rsp_data)
	);

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the character canvas rasterizer top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CANVAS_COLS = 64;
	localparam int CANVAS_ROWS = 32;
	localparam int CYCLE_LIMIT = 25000000;
	localparam logic [2:0] ADDR_WIDTH = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic cmd_valid, cmd_ready;
	ccr_pkg::req_t cmd_data;
	logic rsp_valid, rsp_ready;
	ccr_pkg::rsp_t rsp_data;

	// The predictor keeps its own copy of the canvas and the active size.
	logic [7:0] shadow_canvas [CANVAS_COLS*CANVAS_ROWS];
	int active_cols, active_rows;
	ccr_pkg::rsp_t pending_reads [$];
	int mismatch_count;
	int cycle_count;

	char_canvas_rasterizer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A global watchdog: the run ends as a failure if it hangs anywhere.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic bit cell_inside(int x, int y);
		return x >= 0 && x < active_cols && y >= 0 && y < active_rows;
	endfunction

	function automatic void put_cell(int x, int y, logic [7:0] c);
		if (cell_inside(x, y))
			shadow_canvas[y*CANVAS_COLS + x] = c;
	endfunction

	function automatic void blank_canvas();
		foreach (shadow_canvas[i])
			shadow_canvas[i] = ccr_pkg::BLANK;
	endfunction

	function automatic void draw_line(int x1, int y1, int x2, int y2, logic [7:0] c);
		int dx, dy, sx, sy, err, e2;
		dx = x2 > x1 ? x2 - x1 : x1 - x2;
		dy = -(y2 > y1 ? y2 - y1 : y1 - y2);
		sx = x1 < x2 ? 1 : -1;
		sy = y1 < y2 ? 1 : -1;
		err = dx + dy;
		forever begin
			put_cell(x1, y1, c);
			if (x1 == x2 && y1 == y2)
				break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				x1 += sx;
			end
			if (e2 <= dx) begin
				err += dx;
				y1 += sy;
			end
		end
	endfunction

	function automatic void draw_outline(int l, int t, int r, int b, logic [7:0] c);
		for (int i = l; i <= r; i++) begin
			put_cell(i, t, c);
			put_cell(i, b, c);
		end
		for (int i = t; i <= b; i++) begin
			put_cell(l, i, c);
			put_cell(r, i, c);
		end
	endfunction

	function automatic void draw_fill(int l, int t, int r, int b, logic [7:0] c);
		if (l < 0) l = 0;
		if (t < 0) t = 0;
		if (r > active_cols - 1) r = active_cols - 1;
		if (b > active_rows - 1) b = active_rows - 1;
		for (int y = t; y <= b; y++)
			for (int x = l; x <= r; x++)
				put_cell(x, y, c);
	endfunction

	function automatic void draw_circle(int cx, int cy, int rad, logic [7:0] c);
		int xi, yi, d;
		xi = 0;
		yi = rad;
		d = ccr_pkg::CIRC_D0 - 2 * rad;
		while (yi >= xi) begin
			put_cell(cx + xi, cy + yi, c);
			put_cell(cx - xi, cy + yi, c);
			put_cell(cx + xi, cy - yi, c);
			put_cell(cx - xi, cy - yi, c);
			put_cell(cx + yi, cy + xi, c);
			put_cell(cx - yi, cy + xi, c);
			put_cell(cx + yi, cy - xi, c);
			put_cell(cx - yi, cy - xi, c);
			if (d < 0) begin
				d += 4 * xi + ccr_pkg::CIRC_INC_A;
			end else begin
				d += 4 * (xi - yi) + ccr_pkg::CIRC_INC_B;
				yi--;
			end
			xi++;
		end
	endfunction

	function automatic void draw_disc(int cx, int cy, int rad, logic [7:0] c);
		int i, j;
		for (int y = 0; y < active_rows; y++) begin
			j = y - cy;
			for (int x = 0; x < active_cols; x++) begin
				i = x - cx;
				if (i * i + j * j <= rad * rad)
					put_cell(x, y, c);
			end
		end
	endfunction

	// Applies one command to the shadow canvas and returns its expected result.
	function automatic ccr_pkg::rsp_t predict_command(ccr_pkg::req_t r);
		ccr_pkg::rsp_t res;
		int xa, ya, xb, yb, rad;
		xa = r.x_a;
		ya = r.y_a;
		xb = r.x_b;
		yb = r.y_b;
		rad = r.radius;
		res = '0;
		case (r.op)
			ccr_pkg::OP_POINT: put_cell(xa, ya, r.draw_char);
			ccr_pkg::OP_LINE: draw_line(xa, ya, xb, yb, r.draw_char);
			ccr_pkg::OP_RECT: draw_outline(xa, ya, xb, yb, r.draw_char);
			ccr_pkg::OP_FILL: draw_fill(xa, ya, xb, yb, r.draw_char);
			ccr_pkg::OP_CIRCLE: draw_circle(xa, ya, rad, r.draw_char);
			ccr_pkg::OP_DISC: draw_disc(xa, ya, rad, r.draw_char);
			ccr_pkg::OP_CLEAR: blank_canvas();
			default: begin
				if (cell_inside(xa, ya)) begin
					res.read_char = shadow_canvas[ya*CANVAS_COLS + xa];
					res.read_inside = 1'b1;
				end
			end
		endcase
		return res;
	endfunction

	// The sender works in bursts; between most bursts it leaves a random gap.
	int burst_left;

	task automatic send_request(ccr_pkg::req_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd_data <= r;
		do @(posedge clk); while (!cmd_ready);
		// The expectation is formed at acceptance, in request order.
		pending_reads.push_back(predict_command(r));
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Registers are written only with nothing in flight; the model saturates them.
	task automatic set_canvas(int cols, int rows);
		wait_drained();
		apb_write(ADDR_WIDTH, 32'(cols));
		apb_write(ADDR_HEIGHT, 32'(rows));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		active_cols = (cols & 7'h7f) > CANVAS_COLS ? CANVAS_COLS : (cols & 7'h7f);
		active_rows = (rows & 6'h3f) > CANVAS_ROWS ? CANVAS_ROWS : (rows & 6'h3f);
	endtask

	function automatic ccr_pkg::req_t make_req(logic [2:0] op, int xa, int ya, int xb,
			int yb, int rad, logic [7:0] c);
		ccr_pkg::req_t r;
		r.op = op;
		r.x_a = 12'(xa);
		r.y_a = 12'(ya);
		r.x_b = 12'(xb);
		r.y_b = 12'(yb);
		r.radius = 11'(rad);
		r.draw_char = c;
		return r;
	endfunction

	// Coordinates mostly near the canvas, sometimes across the full signed range.
	function automatic int rand_coord();
		case ($urandom_range(0, 9))
			0: return int'($urandom_range(0, 4095)) - 2048;
			1: return $urandom_range(0, 1) ? 2047 : -2048;
			default: return int'($urandom_range(0, 79)) - 8;
		endcase
	endfunction

	function automatic ccr_pkg::req_t random_req();
		ccr_pkg::req_t r;
		int rad;
		// Large radii are rare so the circle loop stays short.
		rad = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 40);
		r = make_req(3'($urandom_range(0, 7)), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rad, 8'($urandom_range(0, 255)));
		// Clears are costly and wipe the picture, so most are turned into reads.
		if (r.op == ccr_pkg::OP_CLEAR && $urandom_range(0, 3) != 0)
			r.op = ccr_pkg::OP_READ;
		return r;
	endfunction

	task automatic test_directed_shapes();
		send_request(make_req(ccr_pkg::OP_POINT, 0, 0, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_POINT, 63, 31, 0, 0, 0, 8'hff));
		send_request(make_req(ccr_pkg::OP_POINT, -1, 5, 0, 0, 0, 8'h41));
		send_request(make_req(ccr_pkg::OP_READ, 0, 0, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_READ, 63, 31, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_READ, 64, 0, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_READ, -2048, 2047, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_LINE, -5, -3, 70, 40, 0, 8'h2a));
		send_request(make_req(ccr_pkg::OP_LINE, 10, 20, 10, 20, 0, 8'h2b));
		send_request(make_req(ccr_pkg::OP_RECT, 2, 2, 20, 10, 0, 8'h23));
		send_request(make_req(ccr_pkg::OP_RECT, 30, 5, 25, 12, 0, 8'h24));
		send_request(make_req(ccr_pkg::OP_RECT, 30, 12, 40, 5, 0, 8'h25));
		send_request(make_req(ccr_pkg::OP_FILL, -2048, -2048, 2047, 2047, 0, 8'h2e));
		send_request(make_req(ccr_pkg::OP_FILL, 20, 10, 5, 15, 0, 8'h2f));
		send_request(make_req(ccr_pkg::OP_CIRCLE, 32, 16, 0, 0, 0, 8'h6f));
		send_request(make_req(ccr_pkg::OP_CIRCLE, 32, 16, 0, 0, 12, 8'h4f));
		send_request(make_req(ccr_pkg::OP_DISC, 10, 10, 0, 0, 0, 8'h40));
		send_request(make_req(ccr_pkg::OP_DISC, 50, 20, 0, 0, 7, 8'h26));
		send_request(make_req(ccr_pkg::OP_CIRCLE, 0, 0, 0, 0, 2047, 8'h21));
		send_request(make_req(ccr_pkg::OP_READ, 32, 16, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_READ, 10, 10, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_READ, 5, 5, 0, 0, 0, 8'h00));
	endtask

	task automatic test_canvas_sizes();
		// A small canvas first, then a fill drawn past it and reads on either side of its edge.
		set_canvas(10, 5);
		send_request(make_req(ccr_pkg::OP_FILL, 0, 0, 63, 31, 0, 8'h58));
		send_request(make_req(ccr_pkg::OP_READ, 9, 4, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_READ, 10, 4, 0, 0, 0, 8'h00));
		set_canvas(1, 1);
		send_request(make_req(ccr_pkg::OP_DISC, 0, 0, 0, 0, 3, 8'h59));
		send_request(make_req(ccr_pkg::OP_READ, 0, 0, 0, 0, 0, 8'h00));
		// A zero size clips everything; oversized values saturate.
		set_canvas(0, 0);
		send_request(make_req(ccr_pkg::OP_POINT, 0, 0, 0, 0, 0, 8'h5a));
		send_request(make_req(ccr_pkg::OP_READ, 0, 0, 0, 0, 0, 8'h00));
		set_canvas(127, 63);
		send_request(make_req(ccr_pkg::OP_READ, 63, 31, 0, 0, 0, 8'h00));
		send_request(make_req(ccr_pkg::OP_READ, 15, 15, 0, 0, 0, 8'h00));
	endtask

	task automatic test_random_mix();
		int sizes [4][2] = '{'{64, 32}, '{37, 19}, '{100, 50}, '{8, 30}};
		for (int phase = 0; phase < 4; phase++) begin
			set_canvas(sizes[phase][0], sizes[phase][1]);
			repeat (67) send_request(random_req());
		end
		set_canvas(64, 32);
	endtask

	// The receiver stalls on a pattern of its own: calm stretches and busy ones.
	initial begin
		int stall_mode;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall_mode = $urandom_range(0, 2);
			repeat ($urandom_range(5, 40)) begin
				rsp_ready <= (stall_mode == 0) ? 1'b1 :
					(stall_mode == 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
				@(posedge clk);
			end
		end
	end

	// Each accepted result is checked against the oldest expectation.
	initial begin
		ccr_pkg::rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (pending_reads.size() == 0) begin
					$error("result with no request outstanding: %h", rsp_data);
					mismatch_count++;
				end else begin
					want = pending_reads.pop_front();
					if (rsp_data.read_char !== want.read_char) begin
						$error("read_char expected %h actual %h", want.read_char,
							rsp_data.read_char);
						mismatch_count++;
					end
					if (rsp_data.read_inside !== want.read_inside) begin
						$error("read_inside expected %b actual %b", want.read_inside,
							rsp_data.read_inside);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		mismatch_count = 0;
		burst_left = 0;
		active_cols = ccr_pkg::WIDTH_RESET;
		active_rows = ccr_pkg::HEIGHT_RESET;
		blank_canvas();
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_valid <= 1'b0;
		cmd_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_shapes();
		test_canvas_sizes();
		test_random_mix();

		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && pending_reads.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
